[hdl/efwd_pkg.sv]
// ----------------------------------------------------------------------------
// efwd_pkg: shared types and constants for the earliest-free-worker dispatcher
// Sizes of the worker table and time base, item layout, back-end states and
// the worker-count clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package efwd_pkg;

    // table and time base
    localparam int MAX_WORKERS = 8;
    localparam int TIME_BITS   = 32;

    // fixed port field widths
    localparam int COST_BITS    = 16;
    localparam int IO_TIME_BITS = 32;
    localparam int ID_BITS      = 3;
    localparam int CFG_BITS     = 4;

    // stream packing
    localparam int IN_DATA_BITS   = 48;
    localparam int OUT_FIELD_BITS = ID_BITS + 2 * IO_TIME_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // derived widths
    localparam int IDX_BITS = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_BITS = $clog2(MAX_WORKERS + 1);
    localparam int SUM_BITS = ((TIME_BITS > COST_BITS) ? TIME_BITS : COST_BITS) + 1;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [IDX_BITS-1:0]  idx_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef struct packed {
        time_t ready_time;
        cost_t cost;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_START,
        BK_FINISH
    } back_state_t;

    // zero workers act as one, too many saturate at the table size
    function automatic cnt_t eff_workers(input logic [CFG_BITS-1:0] value);
        cnt_t r;
        if (value == '0) begin
            r = cnt_t'(1);
        end else if (32'(value) > MAX_WORKERS) begin
            r = cnt_t'(MAX_WORKERS);
        end else begin
            r = cnt_t'(value);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/efwd_front.sv]
// ----------------------------------------------------------------------------
// efwd_front: input stage
// Takes items from the input stream, unpacks the fields, brings the ready
// time into the internal time base and holds the item until the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module efwd_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [efwd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output efwd_pkg::item_t                           push_item
);

    logic            valid_reg;
    efwd_pkg::item_t item_reg;
    logic            take;

    // room when empty or when the held item leaves this cycle
    assign s_axis_tready = !valid_reg || push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // hold flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // unpack: ready time in bits 31:0, cost in bits 47:32
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.ready_time <= efwd_pkg::time_t'(s_axis_tdata[31:0]);
            item_reg.cost       <= s_axis_tdata[47:32];
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

`default_nettype wire

[hdl/efwd_queue.sv]
// ----------------------------------------------------------------------------
// efwd_queue: short item queue between front and back
// Register-based FIFO so the front keeps taking items while the back scans.
// ----------------------------------------------------------------------------
`default_nettype none

module efwd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire efwd_pkg::item_t  wr_item,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output efwd_pkg::item_t       rd_item
);

    efwd_pkg::item_t                    entry_reg [efwd_pkg::QUEUE_DEPTH];
    logic [efwd_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [efwd_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [efwd_pkg::QCNT_BITS-1:0]     count_reg;
    logic [efwd_pkg::QPTR_BITS-1:0]     wr_ptr_next;
    logic [efwd_pkg::QPTR_BITS-1:0]     rd_ptr_next;
    logic                               do_wr;
    logic                               do_rd;

    assign wr_ready = (count_reg != efwd_pkg::QCNT_BITS'(efwd_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    // pointer wrap
    always_comb begin
        wr_ptr_next = (wr_ptr_reg == efwd_pkg::QPTR_BITS'(efwd_pkg::QUEUE_DEPTH - 1))
                      ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == efwd_pkg::QPTR_BITS'(efwd_pkg::QUEUE_DEPTH - 1))
                      ? '0 : rd_ptr_reg + 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[hdl/efwd_back.sv]
// ----------------------------------------------------------------------------
// efwd_back: dispatch engine
// Scans the worker free-time table one worker per cycle for the earliest free
// worker, computes start and saturated finish, updates the table and loads
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module efwd_back (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire efwd_pkg::cnt_t                          eff_count,
    input  wire logic                                    rd_valid,
    output logic                                         rd_ready,
    input  wire efwd_pkg::item_t                         rd_item,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [efwd_pkg::ID_BITS-1:0]                 m_worker_id,
    output logic [efwd_pkg::IO_TIME_BITS-1:0]            m_start_time,
    output logic [efwd_pkg::IO_TIME_BITS-1:0]            m_finish_time
);

    efwd_pkg::back_state_t state_reg;
    efwd_pkg::back_state_t state_next;

    efwd_pkg::time_t free_reg [efwd_pkg::MAX_WORKERS];
    efwd_pkg::time_t ready_reg;
    efwd_pkg::cost_t cost_reg;
    efwd_pkg::cnt_t  idx_reg;
    efwd_pkg::idx_t  best_reg;
    efwd_pkg::time_t best_time_reg;
    efwd_pkg::time_t start_reg;

    logic                                 out_valid_reg;
    logic [efwd_pkg::ID_BITS-1:0]         out_id_reg;
    logic [efwd_pkg::IO_TIME_BITS-1:0]    out_start_reg;
    logic [efwd_pkg::IO_TIME_BITS-1:0]    out_finish_reg;

    efwd_pkg::cnt_t                   last_idx;
    efwd_pkg::time_t                  scan_time;
    logic [efwd_pkg::SUM_BITS-1:0]    sum;
    efwd_pkg::time_t                  finish;
    logic                             out_free;
    logic                             pop;
    logic                             fire;

    assign last_idx  = efwd_pkg::cnt_t'(eff_count - 1'b1);
    assign scan_time = free_reg[idx_reg[efwd_pkg::IDX_BITS-1:0]];
    assign out_free  = !out_valid_reg || m_ready;

    // finish = start + cost, saturated at the time maximum
    always_comb begin
        sum    = efwd_pkg::SUM_BITS'(start_reg) + efwd_pkg::SUM_BITS'(cost_reg);
        finish = (|sum[efwd_pkg::SUM_BITS-1:efwd_pkg::TIME_BITS])
                 ? '1 : sum[efwd_pkg::TIME_BITS-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            efwd_pkg::BK_IDLE: begin
                if (rd_valid) begin
                    state_next = (eff_count == efwd_pkg::cnt_t'(1))
                                 ? efwd_pkg::BK_START : efwd_pkg::BK_SCAN;
                end
            end
            efwd_pkg::BK_SCAN: begin
                if (idx_reg == last_idx) begin
                    state_next = efwd_pkg::BK_START;
                end
            end
            efwd_pkg::BK_START: begin
                state_next = efwd_pkg::BK_FINISH;
            end
            efwd_pkg::BK_FINISH: begin
                if (out_free) begin
                    state_next = efwd_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = efwd_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop  = 1'b0;
        fire = 1'b0;
        case (state_reg)
            efwd_pkg::BK_IDLE:   pop  = rd_valid;
            efwd_pkg::BK_FINISH: fire = out_free;
            default: begin
                pop  = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    assign rd_ready = pop;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= efwd_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // worker free-time table: cleared at reset, written by the winner
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < efwd_pkg::MAX_WORKERS; i++) begin
                free_reg[i] <= '0;
            end
        end else if (fire) begin
            free_reg[best_reg] <= finish;
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        if (pop) begin
            ready_reg     <= rd_item.ready_time;
            cost_reg      <= rd_item.cost;
            best_reg      <= '0;
            best_time_reg <= free_reg[0];
            idx_reg       <= efwd_pkg::cnt_t'(1);
        end else if (state_reg == efwd_pkg::BK_SCAN) begin
            // strict less-than keeps the lower index on ties
            if (scan_time < best_time_reg) begin
                best_reg      <= idx_reg[efwd_pkg::IDX_BITS-1:0];
                best_time_reg <= scan_time;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == efwd_pkg::BK_START) begin
            start_reg <= (ready_reg > best_time_reg) ? ready_reg : best_time_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_id_reg     <= efwd_pkg::ID_BITS'(best_reg);
            out_start_reg  <= efwd_pkg::IO_TIME_BITS'(start_reg);
            out_finish_reg <= efwd_pkg::IO_TIME_BITS'(finish);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_worker_id   = out_id_reg;
    assign m_start_time  = out_start_reg;
    assign m_finish_time = out_finish_reg;

endmodule

`default_nettype wire

[hdl/earliest_free_worker_dispatch_core.sv]
// From input acceptance to result valid, an item passes the front stage, the queue and
//   the dispatch engine; active workers range 1..8.
// The dispatch engine takes a new item only once done with the last, paced by the
//   one-compare-per-cycle scan of the worker free-time table; a held result stalls it.
// Reset (aresetn low, synchronous): all worker free times zero, active workers 8,
//   queue and result register empty; no clearing pass.
// ----------------------------------------------------------------------------
// earliest_free_worker_dispatch_core: greedy list scheduler top level
// Front stage and queue feed a dispatch engine that assigns each task to the
// earliest free active worker and reports worker, start and finish time.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_free_worker_dispatch_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [31:0] ready_time, [47:32] cost
    input  wire logic [efwd_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [2:0] worker_id, [34:3] start_time, [66:35] finish_time, rest zero
    output logic [efwd_pkg::OUT_DATA_BITS-1:0]         m_axis_tdata,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [efwd_pkg::CFG_BITS-1:0]         cfg_wr_data
);

    logic [efwd_pkg::CFG_BITS-1:0]        active_workers_reg;
    efwd_pkg::cnt_t                       eff_count;

    logic                                 push_valid;
    logic                                 push_ready;
    efwd_pkg::item_t                      push_item;
    logic                                 rd_valid;
    logic                                 rd_ready;
    efwd_pkg::item_t                      rd_item;

    logic [efwd_pkg::ID_BITS-1:0]         worker_id;
    logic [efwd_pkg::IO_TIME_BITS-1:0]    start_time;
    logic [efwd_pkg::IO_TIME_BITS-1:0]    finish_time;

    // active worker count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_workers_reg <= efwd_pkg::CFG_BITS'(8);
        end else if (cfg_wr_en) begin
            active_workers_reg <= cfg_wr_data;
        end
    end

    assign eff_count = efwd_pkg::eff_workers(active_workers_reg);

    efwd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    efwd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item)
    );

    efwd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eff_count     (eff_count),
        .rd_valid      (rd_valid),
        .rd_ready      (rd_ready),
        .rd_item       (rd_item),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_worker_id   (worker_id),
        .m_start_time  (start_time),
        .m_finish_time (finish_time)
    );

    // pack result item
    assign m_axis_tdata = {{(efwd_pkg::OUT_DATA_BITS - efwd_pkg::OUT_FIELD_BITS){1'b0}},
                           finish_time, start_time, worker_id};

    // the chosen worker is always one of the active ones
    a_worker_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (efwd_pkg::cnt_t'(worker_id) < eff_count))
        else $error("dispatched to an inactive worker");

    // a task never finishes before it starts
    a_finish_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (finish_time >= start_time))
        else $error("finish time below start time");

    // with a single worker everything goes to worker zero
    a_single_worker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (eff_count == efwd_pkg::cnt_t'(1))) |-> (worker_id == '0))
        else $error("single-worker mode dispatched to a nonzero worker");

endmodule

`default_nettype wire
